@@ rtl/bffa_pkg.sv @@
// Shared types and codes for the bitmap first-fit block allocator.
package bffa_pkg;
	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_BAD_SIZE  = 2'd1;
	localparam logic [1:0] ST_NO_RUN    = 2'd2;
	localparam logic [1:0] ST_NOT_FOUND = 2'd3;
	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE  = 1'b1;
	localparam int unsigned PCT_SCALE = 100;
	localparam int unsigned PCT_W     = 7;
endpackage

@@ rtl/bffa_ram.sv @@
// Generic single-port RAM with registered read.
module bffa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end
endmodule

@@ rtl/bffa_pct_div.sv @@
// Restoring divider for the fragmentation percent, one quotient bit a cycle.
module bffa_pct_div #(
	parameter int CW = 11
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic [CW-1:0]           num,
	input  logic [CW-1:0]           den,
	output logic                    done,
	output logic [bffa_pkg::PCT_W-1:0] quo
);
	import bffa_pkg::*;
	localparam int NW = CW + 7;
	localparam int QB = NW;
	logic [NW-1:0] num_q;
	logic [CW:0]   rem_q;
	logic [CW-1:0] den_q;
	logic [$clog2(QB+1)-1:0] cnt_q;
	logic busy_q;
	logic [CW+1:0] trial;
	logic [NW-1:0] scaled;

	// 100*x = 64x + 32x + 4x
	assign scaled = ({7'd0, num} << 6) + ({7'd0, num} << 5) + ({7'd0, num} << 2);
	assign trial = {rem_q, num_q[NW-1]} - {2'b00, den_q};
	assign quo = num_q[PCT_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done <= 1'b0;
			cnt_q <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= (den != '0);
				done <= (den == '0);
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == ($bits(cnt_q))'(QB - 1)) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= (den == '0) ? '0 : scaled;
			rem_q <= '0;
			den_q <= den;
		end else if (busy_q) begin
			if (!trial[CW+1]) begin
				rem_q <= trial[CW:0];
				num_q <= {num_q[NW-2:0], 1'b1};
			end else begin
				rem_q <= {rem_q[CW-1:0], num_q[NW-1]};
				num_q <= {num_q[NW-2:0], 1'b0};
			end
		end
	end
endmodule

@@ rtl/bitmap_first_fit_block_allocator_unit.sv @@
// Top level of the bitmap first-fit block allocator.
// One request is handled at a time. The occupancy bitmap and the run-length
// table sit in single-port RAMs read one block per cycle. After reset a clear
// pass over all POOL_BLOCKS entries runs before the first request is taken.
// An allocate scans the map and marks the run; a free reads the table and
// clears the run. Each request then rescans the map for the longest free run
// and divides for the percent. A result held by out_stall holds the next
// request in the result state.
module bitmap_first_fit_block_allocator_unit #(
	parameter int POOL_BLOCKS = 1024,
	parameter int BLOCK_BYTES = 4096
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        op,
	input  logic [31:0] size_bytes,
	input  logic [21:0] offset,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  status,
	output logic [21:0] granted_offset,
	output logic [10:0] used_blocks,
	output logic [10:0] longest_free_run,
	output logic [6:0]  fragment_percent
);
	import bffa_pkg::*;
	localparam int AW = $clog2(POOL_BLOCKS);
	localparam int CW = $clog2(POOL_BLOCKS + 1);
	localparam int BSH = $clog2(BLOCK_BYTES);

	localparam logic [3:0] S_CLR   = 4'd0;
	localparam logic [3:0] S_IDLE  = 4'd1;
	localparam logic [3:0] S_FIT   = 4'd2;
	localparam logic [3:0] S_MARK  = 4'd3;
	localparam logic [3:0] S_FRD   = 4'd4;
	localparam logic [3:0] S_FCHK  = 4'd5;
	localparam logic [3:0] S_UNMK  = 4'd6;
	localparam logic [3:0] S_LONG  = 4'd7;
	localparam logic [3:0] S_DIV   = 4'd8;
	localparam logic [3:0] S_OUT   = 4'd9;

	logic [3:0] state_q;
	logic [CW:0] idx_q;
	logic [CW-1:0] cur_q, best_q, need_q, used_q, left_q;
	logic [AW-1:0] start_q, base_q;
	logic [1:0] status_q;
	logic op_q;
	logic div_start, div_done;
	logic [PCT_W-1:0] div_quo;

	logic map_we, map_wd, map_rd;
	logic [AW-1:0] map_addr;
	logic len_we;
	logic [AW-1:0] len_addr;
	logic [CW-1:0] len_wd, len_rd;

	logic [32:0] size_round;
	logic [32-BSH:0] need_full;
	logic [CW-1:0] free_cnt;

	assign size_round = {1'b0, size_bytes} + 33'(BLOCK_BYTES - 1);
	assign need_full = size_round[32:BSH];
	assign free_cnt = CW'(POOL_BLOCKS) - used_q;

	bffa_ram #(.WIDTH(1), .DEPTH(POOL_BLOCKS)) u_map (
		.clk(clk), .we(map_we), .addr(map_addr), .wdata(map_wd), .rdata(map_rd));
	bffa_ram #(.WIDTH(CW), .DEPTH(POOL_BLOCKS)) u_len (
		.clk(clk), .we(len_we), .addr(len_addr), .wdata(len_wd), .rdata(len_rd));
	bffa_pct_div #(.CW(CW)) u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .num(free_cnt - best_q),
		.den(free_cnt), .done(div_done), .quo(div_quo));

	// idx_q counts addresses issued; read data lands in the following cycle
	logic scan_rd;
	logic [CW:0] rd_idx;
	assign rd_idx = idx_q - 1'b1;

	always_comb begin
		map_we = 1'b0;
		map_wd = 1'b0;
		map_addr = idx_q[AW-1:0];
		len_we = 1'b0;
		len_wd = '0;
		len_addr = idx_q[AW-1:0];
		div_start = 1'b0;
		scan_rd = (idx_q != '0);
		unique case (state_q)
			S_CLR: begin
				map_we = 1'b1;
				len_we = 1'b1;
			end
			S_MARK: begin
				map_we = 1'b1;
				map_wd = 1'b1;
				map_addr = start_q + idx_q[AW-1:0];
				len_we = (idx_q == '0);
				len_addr = start_q;
				len_wd = need_q;
			end
			S_FRD: begin
				len_addr = base_q;
			end
			S_FCHK: begin
				len_addr = base_q;
				len_we = (len_rd != '0);
			end
			S_UNMK: begin
				map_we = 1'b1;
				map_addr = base_q + idx_q[AW-1:0];
			end
			S_LONG: div_start = 1'b0;
			default: ;
		endcase
		if (state_q == S_LONG && idx_q == CW'(POOL_BLOCKS) + 1) begin
			div_start = 1'b1;
		end
	end

	logic [CW-1:0] cur_nx;
	assign cur_nx = map_rd ? '0 : cur_q + 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
			idx_q <= '0;
			used_q <= '0;
			out_valid <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				out_valid <= 1'b0;
			end
			unique case (state_q)
				S_CLR: begin
					idx_q <= idx_q + 1'b1;
					if (idx_q == (CW+1)'(POOL_BLOCKS - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					idx_q <= '0;
					cur_q <= '0;
					best_q <= '0;
					if (in_valid) begin
						op_q <= op;
						status_q <= ST_OK;
						start_q <= '0;
						if (op == OP_ALLOC) begin
							need_q <= need_full[CW-1:0];
							if (size_bytes == '0 ||
							    need_full > (33-BSH)'(POOL_BLOCKS)) begin
								status_q <= ST_BAD_SIZE;
								state_q <= S_LONG;
							end else begin
								state_q <= S_FIT;
							end
						end else begin
							base_q <= AW'(offset >> BSH);
							if (offset[BSH-1:0] != '0 ||
							    (offset >> BSH) >= 22'(POOL_BLOCKS)) begin
								status_q <= ST_NOT_FOUND;
								state_q <= S_LONG;
							end else begin
								state_q <= S_FRD;
							end
						end
					end
				end
				S_FIT: begin
					idx_q <= idx_q + 1'b1;
					if (scan_rd) begin
						cur_q <= cur_nx;
						if (!map_rd && cur_q + 1'b1 == need_q) begin
							start_q <= AW'(rd_idx + 1'b1 - need_q);
							idx_q <= '0;
							state_q <= S_MARK;
						end else if (idx_q == (CW+1)'(POOL_BLOCKS)) begin
							status_q <= ST_NO_RUN;
							idx_q <= '0;
							cur_q <= '0;
							state_q <= S_LONG;
						end
					end
				end
				S_MARK: begin
					idx_q <= idx_q + 1'b1;
					if (idx_q == (CW+1)'(need_q - 1'b1)) begin
						used_q <= used_q + need_q;
						idx_q <= '0;
						cur_q <= '0;
						state_q <= S_LONG;
					end
				end
				S_FRD: state_q <= S_FCHK;
				S_FCHK: begin
					idx_q <= '0;
					left_q <= len_rd;
					if (len_rd == '0) begin
						status_q <= ST_NOT_FOUND;
						state_q <= S_LONG;
					end else begin
						state_q <= S_UNMK;
					end
				end
				S_UNMK: begin
					idx_q <= idx_q + 1'b1;
					if (idx_q == (CW+1)'(left_q - 1'b1) ||
					    (CW+1)'(base_q) + idx_q == (CW+1)'(POOL_BLOCKS - 1)) begin
						used_q <= used_q - left_q;
						idx_q <= '0;
						cur_q <= '0;
						state_q <= S_LONG;
					end
				end
				S_LONG: begin
					idx_q <= idx_q + 1'b1;
					if (scan_rd && idx_q <= (CW+1)'(POOL_BLOCKS)) begin
						cur_q <= cur_nx;
						if (!map_rd && cur_q + 1'b1 > best_q) begin
							best_q <= cur_q + 1'b1;
						end
					end
					if (idx_q == (CW+1)'(POOL_BLOCKS) + 1) begin
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					if (div_done) begin
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (!out_valid || !out_stall) begin
						out_valid <= 1'b1;
						status <= status_q;
						granted_offset <= (op_q == OP_ALLOC && status_q == ST_OK) ?
							22'({start_q, {BSH{1'b0}}}) : '0;
						used_blocks <= 11'(used_q);
						longest_free_run <= 11'(best_q);
						fragment_percent <= div_quo;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign in_stall = (state_q != S_IDLE);
endmodule
